### rtl/hmr_pkg.sv
// Package with shared constants, register indexes and status codes of the mouse report processor.
package hmr_pkg;

    // Field widths
    localparam int unsigned TimeW     = 48;
    localparam int unsigned StatusW   = 3;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned DeltaW    = 9;
    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 32;

    // Stream payload widths in bits (whole bytes, zero-filled)
    localparam int unsigned InDataW   = 80;
    localparam int unsigned OutDataW  = 96;

    // Transfer status codes
    localparam logic [StatusW-1:0] ST_OK        = 3'd0;
    localparam logic [StatusW-1:0] ST_CANCELED  = 3'd1;
    localparam logic [StatusW-1:0] ST_TRANSIENT = 3'd2;
    localparam logic [StatusW-1:0] ST_UNPLUGGED = 3'd3;
    localparam logic [StatusW-1:0] ST_FATAL     = 3'd4;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] REG_MAP_LEFT       = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_MAP_RIGHT      = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_MAP_MIDDLE     = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_CLICK_INTERVAL = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_WHEEL_ENABLE   = 3'd4;

    // Configuration reset values
    localparam logic [ByteW-1:0]    MAP_LEFT_RST       = 8'd1;
    localparam logic [ByteW-1:0]    MAP_RIGHT_RST      = 8'd2;
    localparam logic [ByteW-1:0]    MAP_MIDDLE_RST     = 8'd4;
    localparam logic [CfgDataW-1:0] CLICK_INTERVAL_RST = 32'd500000;

    // Rapid-error window (2 s in microseconds) and give-up threshold
    localparam logic [TimeW:0]    ERROR_WINDOW_US = 49'd2000000;
    localparam logic [ByteW-1:0]  ERROR_GIVE_UP   = 8'd3;
    localparam logic [ByteW-1:0]  COUNT_MAX       = 8'hFF;

endpackage

### rtl/hid_mouse_report_processor.sv
// Top level of the USB HID boot mouse report processor.
// The block decodes one interrupt-transfer completion per request and returns exactly one
// result for it, in order. Transient errors update a rapid-error counter with a two-second
// window and ask for a requeue below three errors. A successful report is remapped,
// multi-clicks are counted and an event with negated y and wheel movement (wheel only when
// enabled) is emitted. Other status codes, including the unused codes five to seven, give a
// result with neither event nor requeue. Each request passes through an input register and
// a result register. A result is offered on m_tvalid once the result register takes it from
// the input register, which stalls while a result waits. A new request can be accepted every
// cycle while m_tready is high. While a result waits, the input register holds one more
// request and s_tready then falls; s_tready follows m_tready combinationally.
module hid_mouse_report_processor
    import hmr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CfgIndexW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0]   cfg_wdata,
    // Completion request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, from bit 0: now_time[47:0], button_byte[55:48], x_byte[63:56],
    // y_byte[71:64], wheel_byte[79:72]
    input  logic [InDataW-1:0]    s_tdata,
    // s_tuser: transfer_status[2:0]
    input  logic [StatusW-1:0]    s_tuser,
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0: requeue[0], buttons_out[8:1], x_delta[16:9],
    // y_delta[25:17], scroll_delta[34:26], click_total[42:35],
    // event_time[90:43], zero fill[95:91]
    output logic [OutDataW-1:0]   m_tdata,
    // m_tuser: event_valid[0]
    output logic                  m_tuser
);

    // Configuration registers
    logic [ByteW-1:0]    map_left_reg;
    logic [ByteW-1:0]    map_right_reg;
    logic [ByteW-1:0]    map_middle_reg;
    logic [CfgDataW-1:0] click_interval_reg;
    logic                wheel_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_left_reg       <= MAP_LEFT_RST;
            map_right_reg      <= MAP_RIGHT_RST;
            map_middle_reg     <= MAP_MIDDLE_RST;
            click_interval_reg <= CLICK_INTERVAL_RST;
            wheel_enable_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAP_LEFT:       map_left_reg       <= cfg_wdata[ByteW-1:0];
                REG_MAP_RIGHT:      map_right_reg      <= cfg_wdata[ByteW-1:0];
                REG_MAP_MIDDLE:     map_middle_reg     <= cfg_wdata[ByteW-1:0];
                REG_CLICK_INTERVAL: click_interval_reg <= cfg_wdata;
                REG_WHEEL_ENABLE:   wheel_enable_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    logic [StatusW-1:0] status_reg;
    logic [TimeW-1:0]   now_reg;
    logic [ByteW-1:0]   button_reg;
    logic [ByteW-1:0]   x_reg;
    logic [ByteW-1:0]   y_reg;
    logic [ByteW-1:0]   wheel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            status_reg <= s_tuser;
            now_reg    <= s_tdata[47:0];
            button_reg <= s_tdata[55:48];
            x_reg      <= s_tdata[63:56];
            y_reg      <= s_tdata[71:64];
            wheel_reg  <= s_tdata[79:72];
        end
    end

    // Decoder state
    logic [ByteW-1:0] error_count_reg,      error_count_next;
    logic [TimeW-1:0] last_error_stamp_reg, last_error_stamp_next;
    logic [ByteW-1:0] prev_buttons_reg,     prev_buttons_next;
    logic [ByteW-1:0] held_buttons_reg,     held_buttons_next;
    logic [TimeW-1:0] last_click_stamp_reg, last_click_stamp_next;
    logic [ByteW-1:0] click_counter_reg,    click_counter_next;

    // Result fields
    logic              event_valid_next;
    logic              requeue_next;
    logic [ByteW-1:0]  buttons_out_next;
    logic [ByteW-1:0]  x_delta_next;
    logic [DeltaW-1:0] y_delta_next;
    logic [DeltaW-1:0] scroll_delta_next;
    logic [ByteW-1:0]  click_total_next;
    logic [TimeW-1:0]  event_time_next;

    // Decode helpers
    logic [ByteW-1:0]  remapped;
    logic              rapid;
    logic              within_click;
    logic [ByteW-1:0]  ec_dec;

    assign remapped = (button_reg[0] ? map_left_reg   : '0)
                    | (button_reg[1] ? map_right_reg  : '0)
                    | (button_reg[2] ? map_middle_reg : '0);
    assign rapid = {1'b0, now_reg} < ({1'b0, last_error_stamp_reg} + ERROR_WINDOW_US);
    assign within_click = ({1'b0, last_click_stamp_reg}
                           + {{(TimeW + 1 - CfgDataW){1'b0}}, click_interval_reg})
                          > {1'b0, now_reg};
    assign ec_dec = (error_count_reg != '0) ? error_count_reg - 8'd1 : error_count_reg;

    // Completion decode
    always_comb begin
        error_count_next      = error_count_reg;
        last_error_stamp_next = last_error_stamp_reg;
        prev_buttons_next     = prev_buttons_reg;
        held_buttons_next     = held_buttons_reg;
        last_click_stamp_next = last_click_stamp_reg;
        click_counter_next    = click_counter_reg;
        event_valid_next      = 1'b0;
        requeue_next          = 1'b0;
        buttons_out_next      = '0;
        x_delta_next          = '0;
        y_delta_next          = '0;
        scroll_delta_next     = '0;
        click_total_next      = '0;
        event_time_next       = '0;
        if (status_reg == ST_TRANSIENT) begin
            if (rapid) begin
                error_count_next = (error_count_reg != COUNT_MAX)
                                 ? error_count_reg + 8'd1 : error_count_reg;
            end else begin
                error_count_next = ec_dec;
            end
            last_error_stamp_next = now_reg;
            requeue_next          = error_count_next < ERROR_GIVE_UP;
        end else if (status_reg == ST_OK) begin
            error_count_next = ec_dec;
            // A press from no buttons starts or extends a multi-click run.
            if (prev_buttons_reg == '0 && remapped != '0) begin
                if (within_click && remapped == held_buttons_reg) begin
                    click_counter_next = (click_counter_reg != COUNT_MAX)
                                       ? click_counter_reg + 8'd1 : click_counter_reg;
                end else begin
                    click_counter_next = 8'd1;
                end
            end
            if (remapped != '0) begin
                last_click_stamp_next = now_reg;
                held_buttons_next     = remapped;
            end
            prev_buttons_next = remapped;
            event_valid_next  = 1'b1;
            requeue_next      = 1'b1;
            buttons_out_next  = remapped;
            x_delta_next      = x_reg;
            y_delta_next      = -{y_reg[ByteW-1], y_reg};
            scroll_delta_next = wheel_enable_reg ? -{wheel_reg[ByteW-1], wheel_reg} : '0;
            click_total_next  = click_counter_next;
            event_time_next   = now_reg;
        end
    end

    logic do_step;
    assign do_step = in_valid_reg && advance;

    // State update, one completion per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_count_reg      <= '0;
            last_error_stamp_reg <= '0;
            prev_buttons_reg     <= '0;
            held_buttons_reg     <= '0;
            last_click_stamp_reg <= '0;
            click_counter_reg    <= '0;
        end else if (do_step) begin
            error_count_reg      <= error_count_next;
            last_error_stamp_reg <= last_error_stamp_next;
            prev_buttons_reg     <= prev_buttons_next;
            held_buttons_reg     <= held_buttons_next;
            last_click_stamp_reg <= last_click_stamp_next;
            click_counter_reg    <= click_counter_next;
        end
    end

    // Result register
    logic [OutDataW-1:0] out_data_reg;
    logic                out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            out_user_reg <= event_valid_next;
            out_data_reg <= {5'd0, event_time_next, click_total_next, scroll_delta_next,
                             y_delta_next, x_delta_next, buttons_out_next, requeue_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTH
    // An emitted event always comes with a requeue request.
    a_event_requeue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[0])
        else $error("event without requeue");

    // Without an event every payload field but requeue is zero.
    a_no_event_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[OutDataW-1:1] == '0)
        else $error("payload not cleared for a result without event");

    // Held buttons exist only after a press that started a click run.
    a_held_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        held_buttons_reg != '0 |-> click_counter_reg != '0)
        else $error("held buttons with zero click count");
`endif

endmodule
